// ----- rtl/core/brle_pkg.sv -----
package brle_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_NIBBLE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Default for the top-level size parameter
  localparam int MAX_DIM_DEF = 4096;

  // Escape codes after a zero byte
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_RUN   = 3'd1,
    PH_ESC   = 3'd2,
    PH_DX    = 3'd3,
    PH_DY    = 3'd4,
    PH_LIT   = 3'd5,
    PH_PAD   = 3'd6
  } phase_t;

  typedef struct packed {
    logic                  nibble_mode;
    logic [CFG_DATA_W-1:0] image_width;
    logic [CFG_DATA_W-1:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] column;
    logic [7:0]  run_count;
    logic [7:0]  even_index;
    logic [7:0]  odd_index;
    logic        finished;
  } res_t;

  typedef struct packed {
    logic stream_done;
  } stat_t;

endpackage

// ----- rtl/core/brle_if.sv -----
interface brle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface brle_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] row;
  logic [11:0] column;
  logic [7:0]  run_count;
  logic [7:0]  even_index;
  logic [7:0]  odd_index;
  logic        finished;

  modport source (output valid, output row, output column, output run_count,
                  output even_index, output odd_index, output finished, input ready);
  modport sink   (input valid, input row, input column, input run_count,
                  input even_index, input odd_index, input finished, output ready);
endinterface

// ----- rtl/core/brle_cfg_regs.sv -----
module brle_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [brle_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [brle_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output brle_pkg::cfg_t                       cfg
);

  brle_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nibble_mode  <= 1'b0;
      cfg_r.image_width  <= brle_pkg::CFG_DATA_W'(1);
      cfg_r.image_height <= brle_pkg::CFG_DATA_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        brle_pkg::REG_NIBBLE_MODE:  cfg_r.nibble_mode  <= cfg_wdata[0];
        brle_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_wdata;
        brle_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/brle_parser.sv -----
module brle_parser #(
  parameter int MAX_DIM = brle_pkg::MAX_DIM_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  brle_pkg::cfg_t cfg,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic           final_byte,
  output logic           emit,
  output brle_pkg::res_t res,
  output brle_pkg::stat_t stat
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CFG_W = brle_pkg::CFG_DATA_W;
  localparam int AW    = ((DIM_W > CFG_W) ? DIM_W : CFG_W) + 1;
  localparam logic [AW-1:0]    MAX_A = AW'(MAX_DIM);
  localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIM);

  function automatic logic [DIM_W-1:0] sat_add(input logic [DIM_W-1:0] a,
                                               input logic [7:0] b);
    logic [AW-1:0] s;
    s = AW'(a) + AW'(b);
    sat_add = (s > MAX_A) ? MAX_D : s[DIM_W-1:0];
  endfunction

  function automatic logic [7:0] clip_count(input logic [7:0] n,
                                            input logic [DIM_W-1:0] col,
                                            input logic [DIM_W-1:0] width);
    logic [DIM_W-1:0] room;
    room = width - col;
    if (col >= width)
      clip_count = 8'd0;
    else if (AW'(n) < AW'(room))
      clip_count = n;
    else
      clip_count = 8'(room);
  endfunction

  brle_pkg::phase_t phase_r, phase_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [7:0]       lit_r, lit_nxt;
  logic             pad_r, pad_nxt;
  logic             done_r, done_nxt;

  logic [AW-1:0]    w_ext, h_ext;
  logic [DIM_W-1:0] ew, eh;
  logic [7:0]       ev, od;
  logic [7:0]       cnt, lit_n;
  logic [8:0]       lit_bytes;
  logic [DIM_W-1:0] seg_row, seg_col;
  logic             done;

  // effective sizes, limited to MAX_DIM
  assign w_ext = AW'(cfg.image_width);
  assign h_ext = AW'(cfg.image_height);
  assign ew    = (w_ext > MAX_A) ? MAX_D : w_ext[DIM_W-1:0];
  assign eh    = (h_ext > MAX_A) ? MAX_D : h_ext[DIM_W-1:0];

  assign ev = cfg.nibble_mode ? {4'd0, data_byte[7:4]} : data_byte;
  assign od = cfg.nibble_mode ? (data_byte & brle_pkg::NIBBLE_MASK) : data_byte;
  assign lit_bytes = cfg.nibble_mode ? ((9'(data_byte) + 9'd1) >> 1) : 9'(data_byte);

  always_comb begin
    phase_nxt = phase_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    held_nxt  = held_r;
    lit_nxt   = lit_r;
    pad_nxt   = pad_r;
    done_nxt  = done_r;
    emit      = 1'b0;
    res       = '0;
    cnt       = 8'd0;
    lit_n     = 8'd0;
    seg_row   = '0;
    seg_col   = '0;
    done      = 1'b0;

    if (accept && !done_r) begin
      if (row_r >= eh) begin
        // height is no longer above the current row: finish without using the byte
        done_nxt     = 1'b1;
        emit         = 1'b1;
        res.finished = 1'b1;
      end else begin
        case (phase_r)
          brle_pkg::PH_RUN: begin
            seg_row   = row_r;
            seg_col   = col_r;
            cnt       = clip_count(held_r, col_r, ew);
            col_nxt   = sat_add(col_r, held_r);
            phase_nxt = brle_pkg::PH_FIRST;
          end
          brle_pkg::PH_ESC: begin
            if (data_byte == brle_pkg::ESC_EOL) begin
              row_nxt   = sat_add(row_r, 8'd1);
              col_nxt   = '0;
              phase_nxt = brle_pkg::PH_FIRST;
            end else if (data_byte == brle_pkg::ESC_EOB) begin
              done      = 1'b1;
              phase_nxt = brle_pkg::PH_FIRST;
            end else if (data_byte == brle_pkg::ESC_DELTA) begin
              phase_nxt = brle_pkg::PH_DX;
            end else begin
              lit_nxt   = data_byte;
              pad_nxt   = lit_bytes[0];
              phase_nxt = brle_pkg::PH_LIT;
            end
          end
          brle_pkg::PH_DX: begin
            col_nxt   = sat_add(col_r, data_byte);
            phase_nxt = brle_pkg::PH_DY;
          end
          brle_pkg::PH_DY: begin
            row_nxt   = sat_add(row_r, data_byte);
            phase_nxt = brle_pkg::PH_FIRST;
          end
          brle_pkg::PH_LIT: begin
            lit_n = cfg.nibble_mode ? ((lit_r < 8'd2) ? lit_r : 8'd2) : 8'd1;
            if (lit_n > lit_r)
              lit_n = lit_r;
            seg_row = row_r;
            seg_col = col_r;
            cnt     = clip_count(lit_n, col_r, ew);
            col_nxt = sat_add(col_r, lit_n);
            lit_nxt = lit_r - lit_n;
            if (lit_nxt == 8'd0) begin
              phase_nxt = pad_r ? brle_pkg::PH_PAD : brle_pkg::PH_FIRST;
              pad_nxt   = 1'b0;
            end
          end
          brle_pkg::PH_PAD: begin
            phase_nxt = brle_pkg::PH_FIRST;
          end
          default: begin
            // first byte of a pair; unused code lands here too
            if (data_byte == 8'd0) begin
              phase_nxt = brle_pkg::PH_ESC;
            end else begin
              held_nxt  = data_byte;
              phase_nxt = brle_pkg::PH_RUN;
            end
          end
        endcase

        if ((row_nxt >= eh) || final_byte)
          done = 1'b1;
        if (done)
          done_nxt = 1'b1;

        if (cnt != 8'd0) begin
          emit           = 1'b1;
          res.row        = 12'(seg_row);
          res.column     = 12'(seg_col);
          res.run_count  = cnt;
          res.even_index = ev;
          res.odd_index  = od;
          res.finished   = done;
        end else if (done) begin
          emit         = 1'b1;
          res.finished = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= brle_pkg::PH_FIRST;
      row_r   <= '0;
      col_r   <= '0;
      held_r  <= 8'd0;
      lit_r   <= 8'd0;
      pad_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      held_r  <= held_nxt;
      lit_r   <= lit_nxt;
      pad_r   <= pad_nxt;
      done_r  <= done_nxt;
    end
  end

  assign stat.stream_done = done_r;

endmodule

// ----- rtl/core/brle_out_stage.sv -----
module brle_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              emit,
  input  brle_pkg::res_t    res_in,
  output logic              in_ready,
  brle_out_if.source        out_ch
);

  logic           valid_r, valid_nxt;
  brle_pkg::res_t data_r;

  // slot is free when empty or being drained this cycle
  assign in_ready = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ch.ready)
      valid_nxt = 1'b0;
    if (load && emit)
      valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      valid_r <= 1'b0;
    else
      valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load && emit)
      data_r <= res_in;
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.row        = data_r.row;
  assign out_ch.column     = data_r.column;
  assign out_ch.run_count  = data_r.run_count;
  assign out_ch.even_index = data_r.even_index;
  assign out_ch.odd_index  = data_r.odd_index;
  assign out_ch.finished   = data_r.finished;

endmodule

// ----- rtl/core/bmp_rle_run_decoder_top.sv -----
// Channel   Dir  Handshake       Beat payload
// in_ch     in   valid/ready     data_byte[7:0], final_byte
// out_ch    out  valid/ready     row[11:0], column[11:0], run_count[7:0],
//                                even_index[7:0], odd_index[7:0], finished
// cfg_*     in   cfg_we          cfg_index[1:0], cfg_wdata[12:0]
//
// One input beat per cycle while out_ch does not stall; a segment appears on out_ch the cycle after its byte.
// Throughput is set by the single parser state update per byte plus one output register.
// in_ch.ready drops only while a result sits in the output register and out_ch stalls.
// Synchronous active-low reset clears parser state and output valid and sets config to its defaults.
// After the end of decoding, bytes are still taken and discarded until reset.
module bmp_rle_run_decoder_top #(
  parameter int MAX_DIM = brle_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  brle_in_if.sink                         in_ch,
  brle_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [brle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brle_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  brle_pkg::cfg_t  cfg;
  brle_pkg::res_t  res;
  brle_pkg::stat_t stat;
  logic            emit;
  logic            in_ready;
  logic            accept;

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  brle_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // phase tracking, counters and clipping, all in one pass per byte
  brle_parser #(
    .MAX_DIM (MAX_DIM)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .accept     (accept),
    .data_byte  (in_ch.data_byte),
    .final_byte (in_ch.final_byte),
    .emit       (emit),
    .res        (res),
    .stat       (stat)
  );

  // result register decouples the two sides
  brle_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .emit     (emit),
    .res_in   (res),
    .in_ready (in_ready),
    .out_ch   (out_ch)
  );

  // once decoding has ended and the last result is gone, nothing more comes out
  a_quiet_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.stream_done && !out_ch.valid) |=> !out_ch.valid)
    else $error("result after end of decoding");

  // an empty segment is only ever the finish marker
  a_zero_count_finished: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.run_count == 8'd0) |-> out_ch.finished)
    else $error("zero-count segment without finished");

  // finish marker carries cleared position fields
  a_marker_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.run_count == 8'd0) |->
      (out_ch.row == 12'd0 && out_ch.column == 12'd0 &&
       out_ch.even_index == 8'd0 && out_ch.odd_index == 8'd0))
    else $error("finish marker with non-zero fields");

  // input is held off only by a stalled pending result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without output back-pressure");

endmodule
